// ===== rtl/core/chte_pkg.sv =====
// shared types and constants for the chained hash table engine
// used by chained_hash_table_engine_core
package chte_pkg;

  localparam int BUCKET_BITS = 8;
  localparam int SLOT_BITS   = 8;
  localparam int ENTRIES     = 256;
  localparam int PTR_BITS    = 9;
  localparam int VALUE_BITS  = 32;
  localparam int KEY_BITS    = 64;
  localparam int GRP_BITS    = 4;
  localparam int LOW_BITS    = SLOT_BITS - GRP_BITS;
  localparam int NBUCKETS    = 1 << BUCKET_BITS;

  localparam logic [PTR_BITS-1:0] NIL       = PTR_BITS'(ENTRIES);
  localparam logic [63:0]         HASH_MULT = 64'h61C8864680B583EB;

  // operation codes
  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  // status codes
  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_FOUND     = 3'd1;
  localparam logic [2:0] ST_PRESENT   = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;
  localparam logic [2:0] ST_REMOVED   = 3'd5;

  typedef struct packed {
    logic [1:0]            operation;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic [2:0]            status;
    logic [SLOT_BITS-1:0]  slot;
    logic [VALUE_BITS-1:0] value_out;
    logic [PTR_BITS-1:0]   entries_used;
  } rsp_t;

endpackage

// ===== rtl/core/chte_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module chte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/chained_hash_table_engine_core.sv =====
// chained hash table engine: hash, free-slot search, chain walk, update
// depends on chte_pkg and chte_ram
//
// channel | valid     | stall     | payload
// --------+-----------+-----------+--------
// request | req_valid | req_stall | req
// result  | rsp_valid | rsp_stall | rsp
//
// one request at a time; a request runs the hash steps, then for inserts the
// free-slot search, then the chain walk and any table writes.
// an insert into a full table or an unused operation code skips straight to done.
// the chain walk through the slot rams (one read per cycle) sets the rate.
// rst clears control state, bucket valid bits, slot use bits and the count.
// a finished result waits in the output register while rsp_stall is high.
module chained_hash_table_engine_core
  import chte_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  typedef enum logic [12:0] {
    S_IDLE     = 13'b0000000000001,
    S_H0       = 13'b0000000000010,
    S_H1       = 13'b0000000000100,
    S_H2       = 13'b0000000001000,
    S_H3       = 13'b0000000010000,
    S_FREE0    = 13'b0000000100000,
    S_FREE1    = 13'b0000001000000,
    S_HEAD_RD  = 13'b0000010000000,
    S_HEAD_CHK = 13'b0000100000000,
    S_WALK     = 13'b0001000000000,
    S_UPD0     = 13'b0010000000000,
    S_UPD1     = 13'b0100000000000,
    S_DONE     = 13'b1000000000000
  } state_t;

  state_t state;

  // request registers
  logic [1:0]            op;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] val;

  // hash datapath
  logic [31:0]            mul_a, mul_b;
  logic [63:0]            mul_q;
  logic [31:0]            hi;
  logic [31:0]            hi_sum;
  logic [BUCKET_BITS-1:0] bucket;

  // table control state
  logic [ENTRIES-1:0]  in_use;
  logic [NBUCKETS-1:0] head_valid;
  logic                hv_q;
  logic [PTR_BITS-1:0] count;

  // free-slot search
  logic [GRP_BITS-1:0]  fr_grp;
  logic [SLOT_BITS-1:0] fr;
  logic [GRP_BITS-1:0]  grp_pick;
  logic [LOW_BITS-1:0]  low_pick;
  logic [(1<<LOW_BITS)-1:0] grp_bits;

  // walk
  logic [PTR_BITS-1:0] cur, prev, hit_link, head_cur;

  // result
  logic [2:0]            res_status;
  logic [SLOT_BITS-1:0]  res_slot;
  logic [VALUE_BITS-1:0] res_value;

  // memory ports
  logic                           head_we;
  logic [BUCKET_BITS-1:0]         head_waddr;
  logic [PTR_BITS-1:0]            head_wdata, head_rd;
  logic                           kv_we;
  logic [KEY_BITS+VALUE_BITS-1:0] kv_rd;
  logic                           link_we;
  logic [SLOT_BITS-1:0]           link_waddr, slot_raddr;
  logic [PTR_BITS-1:0]            link_wdata, link_rd;
  logic [KEY_BITS-1:0]            rd_key;
  logic [VALUE_BITS-1:0]          rd_val;

  assign req_stall = (state != S_IDLE);
  assign rd_key    = kv_rd[KEY_BITS+VALUE_BITS-1:VALUE_BITS];
  assign rd_val    = kv_rd[VALUE_BITS-1:0];
  assign head_cur  = hv_q ? head_rd : NIL;
  assign hi_sum    = hi + mul_q[31:0];

  chte_ram #(.WIDTH(PTR_BITS), .DEPTH(NBUCKETS)) u_head_ram (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .raddr(bucket), .rdata(head_rd)
  );

  chte_ram #(.WIDTH(KEY_BITS+VALUE_BITS), .DEPTH(ENTRIES)) u_kv_ram (
    .clk(clk), .we(kv_we), .waddr(fr), .wdata({key, val}),
    .raddr(slot_raddr), .rdata(kv_rd)
  );

  chte_ram #(.WIDTH(PTR_BITS), .DEPTH(ENTRIES)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(slot_raddr), .rdata(link_rd)
  );

  // shared hash multiplier operands: low and cross partial products
  always_comb begin
    mul_a = key[31:0];
    mul_b = HASH_MULT[31:0];
    case (state)
      S_H1:    mul_b = HASH_MULT[63:32];
      S_H2:    mul_a = key[63:32];
      default: ;
    endcase
  end

  // lowest group holding an unused slot
  always_comb begin
    grp_pick = '0;
    for (int g = (1 << GRP_BITS) - 1; g >= 0; g--) begin
      if (!(&in_use[g*(1<<LOW_BITS) +: (1<<LOW_BITS)])) begin
        grp_pick = GRP_BITS'(g);
      end
    end
  end

  // lowest unused slot inside the chosen group
  always_comb begin
    grp_bits = in_use[fr_grp*(1<<LOW_BITS) +: (1<<LOW_BITS)];
    low_pick = '0;
    for (int i = (1 << LOW_BITS) - 1; i >= 0; i--) begin
      if (!grp_bits[i]) begin
        low_pick = LOW_BITS'(i);
      end
    end
  end

  // slot ram read address: chain head, then successive links
  always_comb begin
    slot_raddr = link_rd[SLOT_BITS-1:0];
    if (state == S_HEAD_CHK) begin
      slot_raddr = head_cur[SLOT_BITS-1:0];
    end
  end

  // table writes
  always_comb begin
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = {1'b0, fr};
    kv_we      = 1'b0;
    link_we    = 1'b0;
    link_waddr = fr;
    link_wdata = NIL;
    if (state == S_UPD0) begin
      if (op == OP_INSERT) begin
        kv_we   = 1'b1;
        link_we = 1'b1;
        head_we = prev[PTR_BITS-1];
      end else begin
        head_wdata = hit_link;
        link_wdata = hit_link;
        link_waddr = prev[SLOT_BITS-1:0];
        head_we    = prev[PTR_BITS-1];
        link_we    = !prev[PTR_BITS-1];
      end
    end else if (state == S_UPD1) begin
      link_we    = 1'b1;
      link_waddr = prev[SLOT_BITS-1:0];
      link_wdata = {1'b0, fr};
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_use     <= '0;
      head_valid <= '0;
      count      <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      // a beat taken outside the done state empties the output register
      if (rsp_valid && !rsp_stall && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      mul_q <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            op    <= req.operation;
            key   <= req.key;
            val   <= req.value_in;
            state <= S_H0;
          end
        end
        S_H0: state <= S_H1;
        S_H1: begin
          hi    <= mul_q[63:32];
          state <= S_H2;
        end
        S_H2: begin
          hi    <= hi_sum;
          state <= S_H3;
        end
        S_H3: begin
          bucket     <= hi_sum[31 -: BUCKET_BITS];
          res_status <= ST_NOT_FOUND;
          res_slot   <= '0;
          res_value  <= '0;
          if (op == OP_INSERT) begin
            if (count == NIL) begin
              res_status <= ST_FULL;
              state      <= S_DONE;
            end else begin
              state <= S_FREE0;
            end
          end else if (op == OP_LOOKUP || op == OP_REMOVE) begin
            state <= S_HEAD_RD;
          end else begin
            state <= S_DONE;
          end
        end
        S_FREE0: begin
          fr_grp <= grp_pick;
          state  <= S_FREE1;
        end
        S_FREE1: begin
          fr    <= {fr_grp, low_pick};
          state <= S_HEAD_RD;
        end
        S_HEAD_RD: begin
          hv_q  <= head_valid[bucket];
          prev  <= NIL;
          state <= S_HEAD_CHK;
        end
        S_HEAD_CHK: begin
          cur <= head_cur;
          if (head_cur[PTR_BITS-1]) begin
            state <= (op == OP_INSERT) ? S_UPD0 : S_DONE;
          end else begin
            state <= S_WALK;
          end
        end
        S_WALK: begin
          if (rd_key == key) begin
            res_slot  <= cur[SLOT_BITS-1:0];
            res_value <= rd_val;
            hit_link  <= link_rd;
            case (op)
              OP_INSERT: begin
                res_status <= ST_PRESENT;
                state      <= S_DONE;
              end
              OP_LOOKUP: begin
                res_status <= ST_FOUND;
                state      <= S_DONE;
              end
              default: state <= S_UPD0;
            endcase
          end else begin
            prev <= cur;
            cur  <= link_rd;
            if (link_rd[PTR_BITS-1]) begin
              state <= (op == OP_INSERT) ? S_UPD0 : S_DONE;
            end
          end
        end
        S_UPD0: begin
          if (op == OP_INSERT) begin
            in_use[fr] <= 1'b1;
            count      <= count + 1'b1;
            res_status <= ST_INSERTED;
            res_slot   <= fr;
            res_value  <= '0;
            if (prev[PTR_BITS-1]) begin
              head_valid[bucket] <= 1'b1;
              state              <= S_DONE;
            end else begin
              state <= S_UPD1;
            end
          end else begin
            in_use[res_slot] <= 1'b0;
            if (count != '0) begin
              count <= count - 1'b1;
            end
            if (prev[PTR_BITS-1]) begin
              head_valid[bucket] <= 1'b1;
            end
            res_status <= ST_REMOVED;
            state      <= S_DONE;
          end
        end
        S_UPD1: state <= S_DONE;
        S_DONE: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid        <= 1'b1;
            rsp.status       <= res_status;
            rsp.slot         <= res_slot;
            rsp.value_out    <= res_value;
            rsp.entries_used <= count;
            state            <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= NIL)
    else $error("entry count above capacity");

  a_walk_cur: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> !cur[PTR_BITS-1])
    else $error("chain walk on end-of-chain pointer");

  a_insert_marks: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD0 && op == OP_INSERT) |=> in_use[fr])
    else $error("inserted slot not marked in use");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_DONE))
    else $error("result beat not from done state");
`endif

endmodule
